// File: rtl/fdpe_pkg.sv
package fdpe_pkg;

  localparam int unsigned ModulesDef = 8;
  localparam int unsigned ModulesMax = 64;
  localparam int unsigned IdW        = 11;
  localparam int unsigned SlotW      = 6;   // width of id[10:5]
  localparam int unsigned IndexW     = 3;
  localparam int unsigned MaskW      = 8;

  localparam logic [3:0]  CodeVolt    = 4'h4;
  localparam logic [3:0]  CodeTemp    = 4'hD;
  localparam logic [7:0]  SeedMinTemp = 8'd100;
  localparam logic [15:0] SeedMinVolt = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  max_temp;
    logic [7:0]  min_temp;
    logic [15:0] max_volt;
    logic [15:0] min_volt;
  } extremes_t;

  typedef struct packed {
    logic              wr_volt;
    logic              wr_temp;
    logic [SlotW-1:0]  slot;
    logic [15:0]       max_volt;
    logic [15:0]       min_volt;
    logic [7:0]        max_temp;
    logic [7:0]        min_temp;
  } table_wr_t;

endpackage

// File: rtl/fdpe_cell.sv
module fdpe_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fdpe_pkg::table_wr_t   wr_i,
  input  logic                  present_i,
  input  logic                  tok_i,
  input  fdpe_pkg::extremes_t   acc_i,
  output logic                  tok_o,
  output fdpe_pkg::extremes_t   acc_o
);

  logic [15:0] max_volt_q, min_volt_q;
  logic [7:0]  max_temp_q, min_temp_q;
  logic        sel;
  logic        tok_q;
  fdpe_pkg::extremes_t acc_d, acc_q;

  assign sel = (wr_i.slot == fdpe_pkg::SlotW'(Idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_volt_q <= '0;
      min_volt_q <= '0;
      max_temp_q <= '0;
      min_temp_q <= '0;
    end else begin
      if (sel && wr_i.wr_volt) begin
        max_volt_q <= wr_i.max_volt;
        min_volt_q <= wr_i.min_volt;
      end
      if (sel && wr_i.wr_temp) begin
        max_temp_q <= wr_i.max_temp;
        min_temp_q <= wr_i.min_temp;
      end
    end
  end

  // fold this module's entries into the running extremes
  always_comb begin
    acc_d = acc_i;
    if (present_i) begin
      if (max_temp_q > acc_i.max_temp) acc_d.max_temp = max_temp_q;
      if (min_temp_q < acc_i.min_temp) acc_d.min_temp = min_temp_q;
      if (max_volt_q > acc_i.max_volt) acc_d.max_volt = max_volt_q;
      if (min_volt_q < acc_i.min_volt) acc_d.min_volt = min_volt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      acc_q <= acc_d;
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

// File: rtl/module_frame_decode_pack_extremes.sv
// Battery-module frame decoder. An item is taken when start is high and busy
// is low; the table write happens at that edge, then a token sweeps the row of
// per-module cells, one cell per cycle, folding in the present modules. The
// result shows on the outputs for one cycle with done_o high, once the token
// has left the last cell, and is taken at the edge that ends that cycle; the
// receiver cannot stall it and must take it then. busy drops at that same edge,
// so a new item is taken only after the last one's result is out. present_mask
// is written through the cfg_* channel, which is ready whenever busy is low.
module module_frame_decode_pack_extremes #(
  parameter int unsigned MODULES = fdpe_pkg::ModulesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] frame_id_i,
  input  logic [7:0]  byte_0_i,
  input  logic [7:0]  byte_1_i,
  input  logic [7:0]  byte_2_i,
  input  logic [7:0]  byte_3_i,
  input  logic [7:0]  byte_4_i,
  input  logic [7:0]  byte_5_i,
  output logic        done_o,
  output logic [2:0]  module_index_o,
  output logic        stored_o,
  output logic [7:0]  pack_max_temp_o,
  output logic [7:0]  pack_min_temp_o,
  output logic [15:0] pack_max_volt_o,
  output logic [15:0] pack_min_volt_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic                                 busy_q;
  logic                                 launch_q;
  logic [fdpe_pkg::MaskW-1:0]           mask_q;
  logic [fdpe_pkg::IndexW-1:0]          index_q;
  logic                                 stored_q;
  logic                                 accept;
  logic [3:0]                           code;
  logic [fdpe_pkg::SlotW-1:0]           raw_slot, slot;
  fdpe_pkg::table_wr_t                  wr;
  logic                                 tok [MODULES+1];
  fdpe_pkg::extremes_t                  acc [MODULES+1];

  assign accept   = start && !busy_q;
  assign code     = frame_id_i[3:0];
  assign raw_slot = frame_id_i[10:5];
  // one extra bit so that MODULES = 64 never clamps
  assign slot     = ({1'b0, raw_slot} >= (fdpe_pkg::SlotW + 1)'(MODULES)) ? '0 : raw_slot;

  always_comb begin
    wr.wr_volt  = accept && (code == fdpe_pkg::CodeVolt);
    wr.wr_temp  = accept && (code == fdpe_pkg::CodeTemp);
    wr.slot     = slot;
    wr.max_volt = {byte_0_i, byte_1_i};
    wr.min_volt = {byte_2_i, byte_3_i};
    wr.max_temp = byte_4_i;
    wr.min_temp = byte_5_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      mask_q   <= '0;
    end else begin
      launch_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok[MODULES]) begin
        busy_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q  <= slot[fdpe_pkg::IndexW-1:0];
      stored_q <= wr.wr_volt || wr.wr_temp;
    end
  end

  assign tok[0]          = launch_q;
  assign acc[0].max_temp = '0;
  assign acc[0].min_temp = fdpe_pkg::SeedMinTemp;
  assign acc[0].max_volt = '0;
  assign acc[0].min_volt = fdpe_pkg::SeedMinVolt;

  for (genvar i = 0; i < MODULES; i++) begin : g_cell
    logic present;
    if (i < fdpe_pkg::MaskW) begin : g_mask
      assign present = mask_q[i];
    end else begin : g_nomask
      assign present = 1'b0;
    end

    fdpe_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .present_i(present),
      .tok_i    (tok[i]),
      .acc_i    (acc[i]),
      .tok_o    (tok[i+1]),
      .acc_o    (acc[i+1])
    );
  end

  assign busy            = busy_q;
  assign cfg_ready_o     = !busy_q;
  assign done_o          = tok[MODULES];
  assign module_index_o  = index_q;
  assign stored_o        = stored_q;
  assign pack_max_temp_o = acc[MODULES].max_temp;
  assign pack_min_temp_o = acc[MODULES].min_temp;
  assign pack_max_volt_o = acc[MODULES].max_volt;
  assign pack_min_volt_o = acc[MODULES].min_volt;

endmodule
